[design/table_driven_dfa_matcher_unit_defines.svh]
// Assertion macros shared by the matcher unit's checks.
`ifndef TABLE_DRIVEN_DFA_MATCHER_UNIT_DEFINES_SVH
`define TABLE_DRIVEN_DFA_MATCHER_UNIT_DEFINES_SVH

// The condition must never hold while out of reset.
`define TDDM_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("tddm check failed: forbidden condition");

// The consequence must hold in the same cycle as the cause.
`define TDDM_ASSERT_IMPL(label, cause, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |-> (conseq)) \
        else $error("tddm check failed: implication");

// The consequence must hold in the cycle after the cause.
`define TDDM_ASSERT_NEXT(label, cause, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (conseq)) \
        else $error("tddm check failed: next-cycle implication");

`endif

[design/tddm_pkg.sv]
// Shared types, constants and helper functions of the DFA matcher unit.
`timescale 1ns / 1ps

package tddm_pkg;

    localparam int STATE_COUNT = 16;
    localparam int SYMBOL_BITS = 8;
    localparam int STATE_W     = 4;
    localparam int SYM_W       = 8;
    localparam int SLOT_COUNT  = STATE_COUNT << SYMBOL_BITS;
    localparam int SLOT_BITS   = $clog2(SLOT_COUNT);
    localparam int TERM_BITS   = $clog2(STATE_COUNT);

    typedef enum logic [1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_MARK   = 2'd1,
        FUNC_SYMBOL = 2'd2,
        FUNC_END    = 2'd3
    } func_t;

    typedef struct packed {
        logic               valid;
        logic [STATE_W-1:0] next;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        func_t                func;
        logic [SLOT_BITS-1:0] addr;
        logic [STATE_W-1:0]   src;
        logic [STATE_W-1:0]   dst;
        logic                 load_ok;
        logic                 sym_ok;
        logic                 fwd_hit;
        entry_t               fwd_entry;
    } pend_t;

    typedef struct packed {
        logic                 en;
        logic [SLOT_BITS-1:0] addr;
        entry_t               data;
    } wr_t;

    typedef struct packed {
        logic               kind;
        logic [STATE_W-1:0] state_now;
        logic               no_transition;
        logic               accepted;
    } result_t;

    function automatic logic state_ok(logic [STATE_W-1:0] s);
        return int'(s) < STATE_COUNT;
    endfunction

    function automatic logic sym_ok(logic [SYM_W-1:0] sym);
        return (32'(sym) >> SYMBOL_BITS) == 32'd0;
    endfunction

endpackage

[design/tddm_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module tddm_ram #(
    parameter int WIDTH     = 8,
    parameter int DEPTH     = 16,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/tddm_step.sv]
// Resolve stage: applies one item to the automaton state and the transition table.
`timescale 1ns / 1ps

module tddm_step (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           p_valid,
    input  tddm_pkg::pend_t                p,
    input  tddm_pkg::entry_t               rd_entry,
    output tddm_pkg::wr_t                  wr,
    output logic                           res_valid,
    output tddm_pkg::result_t              res,
    output logic [tddm_pkg::STATE_W-1:0]   cur_state
);

    logic [tddm_pkg::STATE_W-1:0]     state_reg;
    logic [tddm_pkg::STATE_W-1:0]     state_next;
    logic                             rej_reg;
    logic                             rej_next;
    logic [tddm_pkg::STATE_COUNT-1:0] term_reg;
    logic [tddm_pkg::STATE_COUNT-1:0] term_next;
    tddm_pkg::entry_t                 eff;

    assign eff = p.fwd_hit ? p.fwd_entry : rd_entry;

    always_comb
    begin
        state_next = state_reg;
        rej_next   = rej_reg;
        term_next  = term_reg;
        wr         = '0;
        res_valid  = 1'b0;
        res        = '0;
        if (p_valid)
        begin
            unique case (p.func)
                tddm_pkg::FUNC_LOAD:
                begin
                    if (p.load_ok && !eff.valid)
                    begin
                        wr.en         = 1'b1;
                        wr.addr       = p.addr;
                        wr.data.valid = 1'b1;
                        wr.data.next  = p.dst;
                    end
                end
                tddm_pkg::FUNC_MARK:
                begin
                    if (tddm_pkg::state_ok(p.src))
                    begin
                        term_next[p.src[tddm_pkg::TERM_BITS-1:0]] = 1'b1;
                    end
                end
                tddm_pkg::FUNC_SYMBOL:
                begin
                    if (!rej_reg)
                    begin
                        if (p.sym_ok && eff.valid)
                        begin
                            state_next = eff.next;
                        end
                        else
                        begin
                            rej_next = 1'b1;
                        end
                    end
                    res_valid         = 1'b1;
                    res.kind          = 1'b0;
                    res.state_now     = state_next;
                    res.no_transition = rej_next;
                    res.accepted      = 1'b0;
                end
                tddm_pkg::FUNC_END:
                begin
                    res_valid         = 1'b1;
                    res.kind          = 1'b1;
                    res.state_now     = state_reg;
                    res.no_transition = rej_reg;
                    res.accepted      = !rej_reg && tddm_pkg::state_ok(state_reg)
                                        && term_reg[state_reg[tddm_pkg::TERM_BITS-1:0]];
                    state_next        = '0;
                    rej_next          = 1'b0;
                end
                default:
                begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            rej_reg   <= 1'b0;
            term_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rej_reg   <= rej_next;
            term_reg  <= term_next;
        end
    end

    assign cur_state = state_reg;

endmodule

[design/tddm_outq.sv]
// Two-word result queue that decouples the resolve stage from the output channel.
`timescale 1ns / 1ps

module tddm_outq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tddm_pkg::result_t push_data,
    input  logic              m_tready,
    output logic              m_tvalid,
    output tddm_pkg::result_t head,
    output logic              full
);

    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    tddm_pkg::result_t slot0_reg;
    tddm_pkg::result_t slot0_next;
    tddm_pkg::result_t slot1_reg;
    tddm_pkg::result_t slot1_next;
    logic              pop;

    assign m_tvalid = count_reg != 2'd0;
    assign pop      = m_tvalid && m_tready;
    assign full     = count_reg == 2'd2;
    assign head     = slot0_reg;

    always_comb
    begin
        count_next = count_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        unique case ({push, pop})
            2'b10:
            begin
                if (count_reg == 2'd0)
                begin
                    slot0_next = push_data;
                end
                else
                begin
                    slot1_next = push_data;
                end
                count_next = count_reg + 2'd1;
            end
            2'b01:
            begin
                slot0_next = slot1_reg;
                count_next = count_reg - 2'd1;
            end
            2'b11:
            begin
                if (count_reg == 2'd1)
                begin
                    slot0_next = push_data;
                end
                else
                begin
                    slot0_next = slot1_reg;
                    slot1_next = push_data;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

[design/table_driven_dfa_matcher_unit.sv]
// Top level of the table-driven DFA matcher unit.
//
// Channel  Dir  tdata                                   tuser
// s_*      in   src_state, symbol, dst_state (16 bits)  func (2 bits)
// m_*      out  state_now, no_transition, accepted      kind (1 bit)
//
// Loads may follow each other every cycle unless the result queue is full.
// A symbol or end word holds off the next input word until it has resolved, set by the
// registered read of the transition RAM whose address holds the state that the previous symbol produced.
// After reset a clearing pass writes all 4096 table entries, one a cycle, before any
// word is accepted.
// A two-word result queue lets input continue while a result waits on m_tready.
`timescale 1ns / 1ps
`include "table_driven_dfa_matcher_unit_defines.svh"

module table_driven_dfa_matcher_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [3:0] src_state, [11:4] symbol, [15:12] dst_state
    input  logic [1:0]  s_tuser,   // [1:0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [3:0] state_now, [4] no_transition, [5] accepted
    output logic [0:0]  m_tuser    // [0] kind
);

    localparam int SB = tddm_pkg::SLOT_BITS;

    logic                          clr_active_reg;
    logic                          clr_active_next;
    logic [SB-1:0]                 clr_addr_reg;
    logic [SB-1:0]                 clr_addr_next;
    logic                          p_valid_reg;
    logic                          p_valid_next;
    tddm_pkg::pend_t               pend_reg;
    tddm_pkg::pend_t               pend_next;
    tddm_pkg::func_t               in_func;
    logic [tddm_pkg::STATE_W-1:0]  in_src;
    logic [tddm_pkg::SYM_W-1:0]    in_sym;
    logic [tddm_pkg::STATE_W-1:0]  in_dst;
    logic [tddm_pkg::STATE_W-1:0]  rd_state;
    logic [SB-1:0]                 rd_addr;
    logic                          accept;
    logic                          p_res;
    logic                          q_full;
    tddm_pkg::wr_t                 step_wr;
    tddm_pkg::wr_t                 mem_wr;
    logic [tddm_pkg::ENTRY_W-1:0]  rd_data;
    tddm_pkg::entry_t              rd_entry;
    logic                          res_valid;
    tddm_pkg::result_t             res;
    tddm_pkg::result_t             head;
    logic [tddm_pkg::STATE_W-1:0]  cur_state;

    assign in_func = tddm_pkg::func_t'(s_tuser);
    assign in_src  = s_tdata[3:0];
    assign in_sym  = s_tdata[11:4];
    assign in_dst  = s_tdata[15:12];

    assign p_res    = p_valid_reg && (pend_reg.func == tddm_pkg::FUNC_SYMBOL
                                   || pend_reg.func == tddm_pkg::FUNC_END);
    assign s_tready = !clr_active_reg && !p_res && !q_full;
    assign accept   = s_tvalid && s_tready;

    assign rd_state = (in_func == tddm_pkg::FUNC_SYMBOL) ? cur_state : in_src;
    assign rd_addr  = SB'({rd_state, in_sym[tddm_pkg::SYMBOL_BITS-1:0]});

    always_comb
    begin
        pend_next.func      = in_func;
        pend_next.addr      = rd_addr;
        pend_next.src       = in_src;
        pend_next.dst       = in_dst;
        pend_next.sym_ok    = tddm_pkg::sym_ok(in_sym);
        pend_next.load_ok   = tddm_pkg::state_ok(in_src) && tddm_pkg::state_ok(in_dst)
                              && tddm_pkg::sym_ok(in_sym);
        pend_next.fwd_hit   = step_wr.en && (step_wr.addr == rd_addr);
        pend_next.fwd_entry = step_wr.data;
        p_valid_next        = accept;
    end

    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            mem_wr.en   = 1'b1;
            mem_wr.addr = clr_addr_reg;
            mem_wr.data = '0;
            if (clr_addr_reg == SB'(tddm_pkg::SLOT_COUNT - 1))
            begin
                clr_active_next = 1'b0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + SB'(1);
            end
        end
        else
        begin
            mem_wr = step_wr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            p_valid_reg    <= 1'b0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            p_valid_reg    <= p_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

    tddm_ram #(
        .WIDTH (tddm_pkg::ENTRY_W),
        .DEPTH (tddm_pkg::SLOT_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (mem_wr.en),
        .waddr (mem_wr.addr),
        .wdata (mem_wr.data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign rd_entry = tddm_pkg::entry_t'(rd_data);

    tddm_step u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .p_valid   (p_valid_reg),
        .p         (pend_reg),
        .rd_entry  (rd_entry),
        .wr        (step_wr),
        .res_valid (res_valid),
        .res       (res),
        .cur_state (cur_state)
    );

    tddm_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .head      (head),
        .full      (q_full)
    );

    assign m_tdata = {2'b00, head.accepted, head.no_transition, head.state_now};
    assign m_tuser = head.kind;

    `TDDM_ASSERT_IMPL(a_no_accept_in_clear, clr_active_reg, !s_tready)
    `TDDM_ASSERT_NEVER(a_no_step_write_in_clear, clr_active_reg && step_wr.en)
    `TDDM_ASSERT_IMPL(a_symbol_spacing, p_res, !(s_tvalid && s_tready))
    `TDDM_ASSERT_NEXT(a_result_reaches_queue, res_valid, m_tvalid)

endmodule

[bench/tb.sv]
// Self-checking testbench for the table-driven DFA matcher unit.
`timescale 1ns / 1ps

module tb;

    localparam int SYM_SPAN  = 1 << tddm_pkg::SYMBOL_BITS;
    localparam int ST_W      = tddm_pkg::STATE_W;
    localparam int SY_W      = tddm_pkg::SYM_W;
    localparam int SL_W      = tddm_pkg::SLOT_BITS;
    localparam int MAX_CYCLE = 200000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [3:0] src_state, [11:4] symbol, [15:12] dst_state
    logic [1:0]  s_tuser;   // [1:0] func
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [3:0] state_now, [4] no_transition, [5] accepted
    logic [0:0]  m_tuser;   // [0] kind

    logic [ST_W-1:0] next_state_tbl [tddm_pkg::SLOT_COUNT];
    bit              slot_ok        [tddm_pkg::SLOT_COUNT];
    bit              terminal       [tddm_pkg::STATE_COUNT];
    logic [ST_W-1:0] cur_state = '0;
    bit              rejected  = 1'b0;

    tddm_pkg::result_t pending_reports [$];
    logic [SY_W-1:0]   sym_pool [4];
    bit                idle_en     = 1'b1;
    int                mismatches  = 0;
    int                words_sent  = 0;
    int                cycle_count = 0;

    table_driven_dfa_matcher_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [SL_W-1:0] slot_of(logic [ST_W-1:0] st, logic [SY_W-1:0] sym);
        return SL_W'({st, sym[tddm_pkg::SYMBOL_BITS-1:0]});
    endfunction

    function automatic logic [ST_W-1:0] rand_state();
        return ST_W'($urandom_range(0, 15));
    endfunction

    function automatic logic [SY_W-1:0] rand_sym();
        return SY_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [1:0] rand_pick();
        return 2'($urandom_range(0, 3));
    endfunction

    function automatic bit dfa_advance(tddm_pkg::func_t f, logic [ST_W-1:0] src,
                                       logic [SY_W-1:0] sym, logic [ST_W-1:0] dst,
                                       output tddm_pkg::result_t r);
        logic [SL_W-1:0] slot;
        bit              hit;
        r = '0;
        case (f)
            tddm_pkg::FUNC_LOAD:
            begin
                if (int'(src) < tddm_pkg::STATE_COUNT && int'(dst) < tddm_pkg::STATE_COUNT
                    && int'(sym) < SYM_SPAN)
                begin
                    slot = slot_of(src, sym);
                    if (!slot_ok[slot])
                    begin
                        slot_ok[slot] = 1'b1;
                        next_state_tbl[slot] = dst;
                    end
                end
                return 1'b0;
            end
            tddm_pkg::FUNC_MARK:
            begin
                if (int'(src) < tddm_pkg::STATE_COUNT)
                    terminal[src] = 1'b1;
                return 1'b0;
            end
            tddm_pkg::FUNC_SYMBOL:
            begin
                if (!rejected)
                begin
                    hit = 1'b0;
                    if (int'(sym) < SYM_SPAN && int'(cur_state) < tddm_pkg::STATE_COUNT)
                    begin
                        slot = slot_of(cur_state, sym);
                        if (slot_ok[slot])
                        begin
                            cur_state = next_state_tbl[slot];
                            hit = 1'b1;
                        end
                    end
                    if (!hit)
                        rejected = 1'b1;
                end
                r.kind          = 1'b0;
                r.state_now     = cur_state;
                r.no_transition = rejected;
                r.accepted      = 1'b0;
                return 1'b1;
            end
            default:
            begin
                r.kind          = 1'b1;
                r.state_now     = cur_state;
                r.no_transition = rejected;
                r.accepted      = !rejected && int'(cur_state) < tddm_pkg::STATE_COUNT
                                  && terminal[cur_state];
                cur_state = '0;
                rejected  = 1'b0;
                return 1'b1;
            end
        endcase
    endfunction

    task automatic report_mismatch(string field, int got, int want);
        $display("tb: mismatch on %s at cycle %0d: got %0d, expected %0d",
                 field, cycle_count, got, want);
        mismatches++;
    endtask

    task automatic send_word(tddm_pkg::func_t f, logic [ST_W-1:0] src, logic [SY_W-1:0] sym,
                             logic [ST_W-1:0] dst);
        tddm_pkg::result_t r;
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {dst, sym, src};
        s_tuser  <= f;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        words_sent++;
        if (dfa_advance(f, src, sym, dst, r))
            pending_reports.push_back(r);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_reports.size() != 0)
            @(posedge clk);
    endtask

    task automatic redraw_pool();
        foreach (sym_pool[i])
            sym_pool[i] = rand_sym();
    endtask

    function automatic logic [SY_W-1:0] next_symbol();
        logic [SY_W-1:0] hits [$];
        if ($urandom_range(0, 7) == 0)
            return rand_sym();
        foreach (sym_pool[i])
            if (slot_ok[slot_of(cur_state, sym_pool[i])])
                hits.push_back(sym_pool[i]);
        if (hits.size() != 0 && $urandom_range(0, 3) != 0)
            return hits[$urandom_range(0, hits.size() - 1)];
        return sym_pool[rand_pick()];
    endfunction

    task automatic test_empty_string();
        send_word(tddm_pkg::FUNC_END, 4'h0, 8'h00, 4'h0);
        send_word(tddm_pkg::FUNC_END, 4'hf, 8'hff, 4'hf);
    endtask

    task automatic test_missing_transition();
        send_word(tddm_pkg::FUNC_SYMBOL, 4'h0, 8'h00, 4'h0);
        send_word(tddm_pkg::FUNC_SYMBOL, 4'hf, 8'hff, 4'hf);
        send_word(tddm_pkg::FUNC_END, 4'h0, 8'h00, 4'h0);
    endtask

    task automatic test_load_rules();
        send_word(tddm_pkg::FUNC_LOAD, 4'h0, 8'h00, 4'hf);
        send_word(tddm_pkg::FUNC_LOAD, 4'h0, 8'h00, 4'h3);
        send_word(tddm_pkg::FUNC_LOAD, 4'hf, 8'hff, 4'h0);
        send_word(tddm_pkg::FUNC_LOAD, 4'hf, 8'h00, 4'hf);
        send_word(tddm_pkg::FUNC_MARK, 4'h0, 8'hff, 4'hf);
        send_word(tddm_pkg::FUNC_MARK, 4'hf, 8'h00, 4'h0);
    endtask

    task automatic test_walk_extremes();
        send_word(tddm_pkg::FUNC_SYMBOL, 4'hf, 8'h00, 4'h0);
        send_word(tddm_pkg::FUNC_SYMBOL, 4'h0, 8'hff, 4'hf);
        send_word(tddm_pkg::FUNC_END, 4'h0, 8'h00, 4'h0);
        send_word(tddm_pkg::FUNC_SYMBOL, 4'h0, 8'h00, 4'h0);
        send_word(tddm_pkg::FUNC_SYMBOL, 4'h0, 8'h00, 4'h0);
        send_word(tddm_pkg::FUNC_SYMBOL, 4'h0, 8'h01, 4'h0);
        send_word(tddm_pkg::FUNC_SYMBOL, 4'h0, 8'hff, 4'h0);
        send_word(tddm_pkg::FUNC_END, 4'h0, 8'h00, 4'h0);
        send_word(tddm_pkg::FUNC_SYMBOL, 4'h0, 8'h00, 4'h0);
        send_word(tddm_pkg::FUNC_END, 4'h0, 8'h00, 4'h0);
    endtask

    task automatic test_random_runs(int word_budget, bit allow_idle);
        int start;
        start = words_sent;
        while (words_sent - start < word_budget)
        begin
            if ($urandom_range(0, 9) == 0)
                redraw_pool();
            idle_en = allow_idle && ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(0, 6))
            begin
                if ($urandom_range(0, 7) == 0)
                    send_word(tddm_pkg::FUNC_LOAD, rand_state(), rand_sym(), rand_state());
                else
                    send_word(tddm_pkg::FUNC_LOAD, rand_state(), sym_pool[rand_pick()],
                              rand_state());
            end
            if ($urandom_range(0, 2) == 0)
                send_word(tddm_pkg::FUNC_MARK, rand_state(), rand_sym(), rand_state());
            repeat ($urandom_range(1, 3))
            begin
                repeat ($urandom_range(0, 10))
                    send_word(tddm_pkg::FUNC_SYMBOL, rand_state(), next_symbol(),
                              rand_state());
                if ($urandom_range(0, 15) != 0)
                    send_word(tddm_pkg::FUNC_END, rand_state(), rand_sym(), rand_state());
            end
        end
    endtask

    task automatic test_drain_pause();
        idle_en = 1'b1;
        repeat (6)
            send_word(tddm_pkg::FUNC_SYMBOL, rand_state(), next_symbol(), rand_state());
        wait_drained();
        send_word(tddm_pkg::FUNC_END, rand_state(), rand_sym(), rand_state());
        wait_drained();
    endtask

    initial
    begin : sink_proc
        int hold;
        hold = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
                m_tready <= 1'b0;
            end
            else if (idle_en && $urandom_range(0, 5) == 0)
            begin
                hold = $urandom_range(1, 4) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_proc
        tddm_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_reports.size() == 0)
                report_mismatch("unexpected word", int'(m_tdata), 0);
            else
            begin
                want = pending_reports.pop_front();
                if (m_tuser[0] !== want.kind)
                    report_mismatch("kind", int'(m_tuser[0]), int'(want.kind));
                if (m_tdata[3:0] !== want.state_now)
                    report_mismatch("state_now", int'(m_tdata[3:0]), int'(want.state_now));
                if (m_tdata[4] !== want.no_transition)
                    report_mismatch("no_transition", int'(m_tdata[4]),
                                    int'(want.no_transition));
                if (m_tdata[5] !== want.accepted)
                    report_mismatch("accepted", int'(m_tdata[5]), int'(want.accepted));
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < MAX_CYCLE)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= tddm_pkg::FUNC_LOAD;
        redraw_pool();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_string();
        test_missing_transition();
        test_load_rules();
        test_walk_extremes();
        test_random_runs(1350, 1'b1);
        test_drain_pause();
        test_random_runs(300, 1'b0);

        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_reports.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
